FILE: rtl/core/lgs_pkg.sv
// Shared types and constants for the toroidal life grid block.
package lgs_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2
  } lgs_action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL_DATA,
    ST_GEN
  } lgs_state_t;

  localparam int unsigned NBR_CNT_W = 4;
  localparam logic [NBR_CNT_W-1:0] BIRTH_CNT   = 4'd3;
  localparam logic [NBR_CNT_W-1:0] SURVIVE_CNT = 4'd2;
  localparam int unsigned COORD_W   = 4;
  localparam int unsigned COORD_CMP_W = 8;

endpackage

FILE: rtl/core/lgs_row_mem.sv
// Row memory of the cell grid with one write and one registered read port.
module lgs_row_mem #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [$clog2(GRID_SIZE)-1:0] wr_addr,
  input  logic [GRID_SIZE-1:0]         wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(GRID_SIZE)-1:0] rd_addr,
  output logic [GRID_SIZE-1:0]         rd_data
);

  logic [GRID_SIZE-1:0] mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_valid_r;
  logic [GRID_SIZE-1:0] rd_q_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid_r <= row_valid_r[rd_addr];
      end
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : '0;

endmodule

FILE: rtl/core/lgs_row_rule.sv
// Next-generation rule for one row from the old rows above, at and below it.
module lgs_row_rule #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  logic [GRID_SIZE-1:0] up_row,
  input  logic [GRID_SIZE-1:0] cur_row,
  input  logic [GRID_SIZE-1:0] down_row,
  output logic [GRID_SIZE-1:0] new_row
);

  import lgs_pkg::*;

  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_cell
    localparam int unsigned L = (c == 0) ? GRID_SIZE - 1 : c - 1;
    localparam int unsigned R = (c == GRID_SIZE - 1) ? 0 : c + 1;
    logic [NBR_CNT_W-1:0] live;

    assign live = NBR_CNT_W'(up_row[L]) + NBR_CNT_W'(up_row[c]) + NBR_CNT_W'(up_row[R])
                + NBR_CNT_W'(cur_row[L]) + NBR_CNT_W'(cur_row[R])
                + NBR_CNT_W'(down_row[L]) + NBR_CNT_W'(down_row[c])
                + NBR_CNT_W'(down_row[R]);
    assign new_row[c] = (live == BIRTH_CNT) || (cur_row[c] && (live == SURVIVE_CNT));
  end

endmodule

FILE: rtl/core/life_grid_generation_step.sv
// Top level of the toroidal life grid: sequencer, cell access and generation sweep.
// The grid lives in a row memory with a registered read. A cell write or read first
// reads the row, then modifies and writes it back or delivers the cell as a beat. In a
// generation the sweep reads one row per cycle through the single read port, keeps the
// rows above and at the current one in registers, and writes each new row back behind
// the read front; the old first row is held for the last row.
// A read result waits in an output register; the next item is taken once it is loaded.
module life_grid_generation_step #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [3:0]            in_row,
  input  logic [3:0]            in_col,
  input  logic                  in_cell_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_cell_alive
);

  import lgs_pkg::*;

  localparam int unsigned AW = $clog2(GRID_SIZE);
  localparam int unsigned SW = $clog2(GRID_SIZE + 3);
  localparam logic [SW-1:0] STEP_LAST = SW'(GRID_SIZE + 2);
  localparam logic [SW-1:0] STEP_RD_LAST = SW'(GRID_SIZE);
  localparam logic [AW-1:0] ROW_LAST = AW'(GRID_SIZE - 1);

  lgs_state_t           state_r, state_nxt;
  lgs_action_t          act_r, act_nxt;
  logic [AW-1:0]        row_r, row_nxt;
  logic [AW-1:0]        col_r, col_nxt;
  logic                 val_r, val_nxt;
  logic                 inside_r, inside_nxt;
  logic [SW-1:0]        step_r, step_nxt;
  logic [GRID_SIZE-1:0] up_r, up_nxt;
  logic [GRID_SIZE-1:0] cur_r, cur_nxt;
  logic [GRID_SIZE-1:0] row0_r, row0_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_cell_alive_r, out_cell_alive_nxt;

  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [GRID_SIZE-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [GRID_SIZE-1:0] mem_rd_data;
  logic [GRID_SIZE-1:0] down_row;
  logic [GRID_SIZE-1:0] rule_row;
  logic [GRID_SIZE-1:0] cell_row;

  logic                 in_inside;
  logic [AW+COORD_W-1:0] in_row_ext;
  logic [AW+COORD_W-1:0] in_col_ext;
  logic [SW-1:0]        step_m1;
  logic [SW-1:0]        step_m3;

  assign in_inside = (COORD_CMP_W'(in_row) < COORD_CMP_W'(GRID_SIZE))
                  && (COORD_CMP_W'(in_col) < COORD_CMP_W'(GRID_SIZE));
  assign in_row_ext = (AW + COORD_W)'(in_row);
  assign in_col_ext = (AW + COORD_W)'(in_col);
  assign step_m1 = step_r - SW'(1);
  assign step_m3 = step_r - SW'(3);
  assign down_row = (step_r == STEP_LAST) ? row0_r : mem_rd_data;

  lgs_row_mem #(
    .GRID_SIZE(GRID_SIZE)
  ) u_row_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  lgs_row_rule #(
    .GRID_SIZE(GRID_SIZE)
  ) u_row_rule (
    .up_row   (up_r),
    .cur_row  (cur_r),
    .down_row (down_row),
    .new_row  (rule_row)
  );

  always_comb begin
    cell_row = mem_rd_data;
    cell_row[col_r] = val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r            <= act_nxt;
    row_r            <= row_nxt;
    col_r            <= col_nxt;
    val_r            <= val_nxt;
    inside_r         <= inside_nxt;
    up_r             <= up_nxt;
    cur_r            <= cur_nxt;
    row0_r           <= row0_nxt;
    out_cell_alive_r <= out_cell_alive_nxt;
  end

  always_comb begin
    state_nxt          = state_r;
    act_nxt            = act_r;
    row_nxt            = row_r;
    col_nxt            = col_r;
    val_nxt            = val_r;
    inside_nxt         = inside_r;
    step_nxt           = step_r;
    up_nxt             = up_r;
    cur_nxt            = cur_r;
    row0_nxt           = row0_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_cell_alive_nxt = out_cell_alive_r;
    mem_wr_en          = 1'b0;
    mem_wr_addr        = row_r;
    mem_wr_data        = cell_row;
    mem_rd_en          = 1'b0;
    mem_rd_addr        = in_row_ext[AW-1:0];
    in_stall           = 1'b1;

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          act_nxt    = lgs_action_t'(in_action);
          row_nxt    = in_row_ext[AW-1:0];
          col_nxt    = in_col_ext[AW-1:0];
          val_nxt    = in_cell_value;
          inside_nxt = in_inside;
          mem_rd_en  = 1'b1;
          case (in_action)
            ACT_WRITE: begin
              if (in_inside) begin
                state_nxt = ST_CELL_DATA;
              end
            end
            ACT_READ: begin
              state_nxt = ST_CELL_DATA;
            end
            ACT_STEP: begin
              state_nxt = ST_GEN;
              step_nxt  = '0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_CELL_DATA: begin
        if (act_r == ACT_WRITE) begin
          mem_wr_en = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_cell_alive_nxt = inside_r && mem_rd_data[col_r];
          state_nxt          = ST_IDLE;
        end
      end

      ST_GEN: begin
        mem_rd_en   = (step_r <= STEP_RD_LAST);
        mem_rd_addr = (step_r == '0) ? ROW_LAST : step_m1[AW-1:0];
        mem_wr_addr = step_m3[AW-1:0];
        mem_wr_data = rule_row;
        step_nxt    = step_r + SW'(1);
        if (step_r == SW'(1)) begin
          up_nxt = mem_rd_data;
        end else if (step_r == SW'(2)) begin
          cur_nxt  = mem_rd_data;
          row0_nxt = mem_rd_data;
        end else if (step_r != '0) begin
          mem_wr_en = 1'b1;
          up_nxt    = cur_r;
          cur_nxt   = mem_rd_data;
        end
        if (step_r == STEP_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_cell_alive_r;

endmodule
